@@ design/alu8rf_pkg.sv @@
// shared types, codes and constants of the 8-bit alu with register file
`default_nettype none
package alu8rf_pkg;

  localparam int BYTE_W      = 8;
  localparam int NUM_REGS    = 6;
  localparam int SIGNED_BASE = 3;
  localparam int REG_AW      = 3;
  localparam int CNT_W       = $clog2(BYTE_W);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [3:0]        op_t;
  typedef logic [1:0]        func_t;
  typedef logic [REG_AW-1:0] reg_idx_t;

  localparam func_t FN_WRITE    = 2'd0;
  localparam func_t FN_READ     = 2'd1;
  localparam func_t FN_EXEC_REG = 2'd2;
  localparam func_t FN_EXEC_IMM = 2'd3;

  localparam op_t OP_ADD  = 4'd0;
  localparam op_t OP_SUB  = 4'd1;
  localparam op_t OP_MUL  = 4'd2;
  localparam op_t OP_DIV  = 4'd3;
  localparam op_t OP_OR   = 4'd4;
  localparam op_t OP_AND  = 4'd5;
  localparam op_t OP_XOR  = 4'd6;
  localparam op_t OP_XNOR = 4'd7;
  localparam op_t OP_NOR  = 4'd8;
  localparam op_t OP_NAND = 4'd9;

  typedef struct packed {
    logic start;
    op_t  op;
    logic sgn_a;
    logic sgn_b;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage
`default_nettype wire

@@ design/alu8rf_ram.sv @@
// generic ram with one write port and two registered read ports
`default_nettype none
module alu8rf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule
`default_nettype wire

@@ design/alu8rf_serial_alu.sv @@
// bit-serial alu: add, sub and logic one bit a cycle, mul and div one step a cycle
`default_nettype none
module alu8rf_serial_alu import alu8rf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_ctl_t ctl,
  input  wire byte_t    a,
  input  wire byte_t    b,
  output alu_sts_t      sts,
  output byte_t         result
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(BYTE_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  op_t              op_r, op_nxt;
  byte_t            a_sh_r, a_sh_nxt;
  byte_t            b_sh_r, b_sh_nxt;
  byte_t            acc_r, acc_nxt;
  byte_t            rem_r, rem_nxt;
  logic             carry_r, carry_nxt;
  logic             neg_r, neg_nxt;

  logic         abit, bbit, sbit, lbit;
  logic         neg_a, neg_b;
  logic [BYTE_W:0] trial, diff;
  logic         ge;

  always_comb begin
    abit  = a_sh_r[0];
    bbit  = b_sh_r[0] ^ (op_r == OP_SUB);
    sbit  = abit ^ bbit ^ carry_r;
    trial = {rem_r, a_sh_r[BYTE_W-1]};
    diff  = trial - {1'b0, b_sh_r};
    ge    = trial >= {1'b0, b_sh_r};
    neg_a = ctl.sgn_a & a[BYTE_W-1];
    neg_b = ctl.sgn_b & b[BYTE_W-1];
    case (op_r)
      OP_ADD, OP_SUB: lbit = sbit;
      OP_OR:          lbit = abit | b_sh_r[0];
      OP_AND:         lbit = abit & b_sh_r[0];
      OP_XOR:         lbit = abit ^ b_sh_r[0];
      OP_XNOR:        lbit = ~(abit ^ b_sh_r[0]);
      OP_NOR:         lbit = ~(abit | b_sh_r[0]);
      OP_NAND:        lbit = ~(abit & b_sh_r[0]);
      default:        lbit = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    a_sh_nxt  = a_sh_r;
    b_sh_nxt  = b_sh_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    carry_nxt = carry_r;
    neg_nxt   = neg_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      op_nxt    = ctl.op;
      acc_nxt   = '0;
      rem_nxt   = '0;
      carry_nxt = (ctl.op == OP_SUB);
      neg_nxt   = neg_a ^ neg_b;
      if (ctl.op == OP_DIV) begin
        a_sh_nxt = neg_a ? byte_t'(~a + 1'b1) : a;
        b_sh_nxt = neg_b ? byte_t'(~b + 1'b1) : b;
      end else begin
        a_sh_nxt = a;
        b_sh_nxt = b;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      case (op_r)
        OP_MUL: begin
          acc_nxt  = acc_r + (b_sh_r[0] ? a_sh_r : byte_t'(0));
          a_sh_nxt = {a_sh_r[BYTE_W-2:0], 1'b0};
          b_sh_nxt = {1'b0, b_sh_r[BYTE_W-1:1]};
        end
        OP_DIV: begin
          rem_nxt  = ge ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0];
          a_sh_nxt = {a_sh_r[BYTE_W-2:0], ge};
        end
        default: begin
          carry_nxt = (abit & bbit) | (abit & carry_r) | (bbit & carry_r);
          acc_nxt   = {lbit, acc_r[BYTE_W-1:1]};
          a_sh_nxt  = {1'b0, a_sh_r[BYTE_W-1:1]};
          b_sh_nxt  = {1'b0, b_sh_r[BYTE_W-1:1]};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    op_r    <= op_nxt;
    a_sh_r  <= a_sh_nxt;
    b_sh_r  <= b_sh_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    carry_r <= carry_nxt;
    neg_r   <= neg_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = (op_r == OP_DIV) ? (neg_r ? byte_t'(~a_sh_r + 1'b1) : a_sh_r) : acc_r;

endmodule
`default_nettype wire

@@ design/alu8_with_register_file.sv @@
// 8-bit alu with a six-entry register file, top level
//
// input channel (in_valid/in_ready) takes one word per item: func, opcode,
// reg_a, reg_b, value_a, value_b. result channel (out_valid/out_ready)
// gives one word per item: result and error.
// register write: the item goes straight to the done state, then to the output register.
// register read: the registered ram read, then the done state and the output register.
// alu operations: ram read, then the serial alu, one bit or one multiply/divide
// step per cycle, then hand-off to the output register.
// a new item is taken when the previous one has moved into the output register.
// errors (bad opcode, bad register, zero divisor) are known before the
// serial alu starts and give result 0; a write to a bad register goes
// straight from acceptance to the done state.
// reset clears the control state and the per-register valid bits, so all
// six registers read as zero after reset.
// if the receiver stalls, the result word holds in the output register
// and at most one more item is accepted and held until it drains.
`default_nettype none
module alu8_with_register_file import alu8rf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire func_t    in_func,
  input  wire op_t      in_opcode,
  input  wire reg_idx_t in_reg_a,
  input  wire reg_idx_t in_reg_b,
  input  wire byte_t    in_value_a,
  input  wire byte_t    in_value_b,
  output logic          out_valid,
  input  wire logic     out_ready,
  output byte_t         out_result,
  output logic          out_error
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam reg_idx_t NREGS = REG_AW'(NUM_REGS);
  localparam reg_idx_t SBASE = REG_AW'(SIGNED_BASE);

  logic [1:0]          state_r, state_nxt;
  func_t               func_r, func_nxt;
  op_t                 op_r, op_nxt;
  reg_idx_t            ra_r, ra_nxt;
  reg_idx_t            rb_r, rb_nxt;
  byte_t               va_r, va_nxt;
  byte_t               vb_r, vb_nxt;
  logic                err_r, err_nxt;
  byte_t               res_r, res_nxt;
  logic [NUM_REGS-1:0] vld_r, vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  byte_t               out_result_r, out_result_nxt;
  logic                out_error_r, out_error_nxt;

  logic     acc;
  logic     bad_a, bad_b, op_bad;
  logic     we;
  byte_t    rdata_a, rdata_b;
  byte_t    opa, opb;
  logic     ok_a, ok_b;
  alu_ctl_t ctl;
  alu_sts_t sts;
  byte_t    alu_result;

  alu8rf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk     (clk),
    .we      (we),
    .waddr   (in_reg_a),
    .wdata   (in_value_a),
    .raddr_a (in_reg_a),
    .rdata_a (rdata_a),
    .raddr_b (in_reg_b),
    .rdata_b (rdata_b)
  );

  alu8rf_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .a      (opa),
    .b      (opb),
    .sts    (sts),
    .result (alu_result)
  );

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign bad_a    = in_reg_a >= NREGS;
  assign bad_b    = in_reg_b >= NREGS;
  assign op_bad   = !(in_opcode inside {[OP_ADD:OP_NAND]});
  assign we       = acc && (in_func == FN_WRITE) && !bad_a;

  always_comb begin
    ok_a = (ra_r < NREGS) ? vld_r[ra_r] : 1'b0;
    ok_b = (rb_r < NREGS) ? vld_r[rb_r] : 1'b0;
    if (func_r == FN_EXEC_IMM) begin
      opa = va_r;
      opb = vb_r;
    end else begin
      opa = ok_a ? rdata_a : byte_t'(0);
      opb = ok_b ? rdata_b : byte_t'(0);
    end
    ctl.start = 1'b0;
    ctl.op    = op_r;
    ctl.sgn_a = (func_r == FN_EXEC_REG) && (ra_r >= SBASE);
    ctl.sgn_b = (func_r == FN_EXEC_REG) && (rb_r >= SBASE);
    if (state_r == S_READ && func_r != FN_READ && !err_r
        && !(op_r == OP_DIV && opb == '0)) begin
      ctl.start = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    op_nxt         = op_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    va_nxt         = va_r;
    vb_nxt         = vb_r;
    err_nxt        = err_r;
    res_nxt        = res_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          func_nxt = in_func;
          op_nxt   = in_opcode;
          ra_nxt   = in_reg_a;
          rb_nxt   = in_reg_b;
          va_nxt   = in_value_a;
          vb_nxt   = in_value_b;
          res_nxt  = '0;
          case (in_func)
            FN_WRITE: begin
              err_nxt   = bad_a;
              state_nxt = S_DONE;
              if (!bad_a) begin
                vld_nxt[in_reg_a] = 1'b1;
              end
            end
            FN_READ: begin
              err_nxt   = bad_a;
              state_nxt = S_READ;
            end
            FN_EXEC_REG: begin
              err_nxt   = bad_a || bad_b || op_bad;
              state_nxt = S_READ;
            end
            default: begin
              err_nxt   = op_bad;
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        if (func_r == FN_READ) begin
          res_nxt   = err_r ? byte_t'(0) : opa;
          state_nxt = S_DONE;
        end else if (ctl.start) begin
          state_nxt = S_RUN;
        end else begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RUN: begin
        if (sts.done) begin
          res_nxt   = alu_result;
          state_nxt = S_DONE;
        end
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = err_r ? byte_t'(0) : res_r;
          out_error_nxt  = err_r;
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    op_r         <= op_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    va_r         <= va_nxt;
    vb_r         <= vb_nxt;
    err_r        <= err_nxt;
    res_r        <= res_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

`ifndef SYNTHESIS
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == S_RUN)
    else $error("serial alu finished outside run state");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !sts.busy)
    else $error("serial alu busy while idle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_result == '0)
    else $error("error word with nonzero result");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> vld_r[$past(in_reg_a)])
    else $error("register write did not set valid bit");
`endif

endmodule
`default_nettype wire
